// File: rtl/rcfs_pkg.sv
package rcfs_pkg;

  // Field widths
  localparam int RAW_W    = 11;
  localparam int VAL_W    = 16;
  localparam int MS_W     = 16;
  localparam int ACT_W    = 2;
  localparam int IDX_W    = 3;
  localparam int MAX_BTNS = 4;

  // Divider geometry: |raw - raw_min| * 2000 fits in 22 bits
  localparam int NUM_W   = 22;
  localparam int QEXT_W  = 24;
  localparam int STEP_W  = 5;
  localparam int DIV_STEPS = NUM_W;

  // Scaling constants
  localparam int SCALE_SPAN   = 2000;
  localparam int SCALE_OFFSET = 1000;
  localparam int SAT_MAX      = 32767;
  localparam int SAT_MIN      = -32768;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_FRAME = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd2;

  // Register indexes (byte address = 4 * index)
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_ACTIVE    = 3'd0;
  localparam logic [2:0] REG_RAW_MIN   = 3'd1;
  localparam logic [2:0] REG_RAW_MAX   = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;

  // Register reset values
  localparam logic             RST_ACTIVE    = 1'b1;
  localparam logic [RAW_W-1:0] RST_RAW_MIN   = 11'd172;
  localparam logic [RAW_W-1:0] RST_RAW_MAX   = 11'd1811;
  localparam logic [RAW_W-1:0] RST_THRESHOLD = 11'd1400;
  localparam logic [MS_W-1:0]  RST_TIMEOUT   = 16'd500;

  localparam int DEF_BUTTON_COUNT = 4;

endpackage

// File: rtl/rcfs_in_if.sv
interface rcfs_in_if;
  logic                        valid;
  logic                        ready;
  logic [rcfs_pkg::ACT_W-1:0]  action;
  logic [rcfs_pkg::RAW_W-1:0]  throttle_raw;
  logic [rcfs_pkg::RAW_W-1:0]  steer_raw;
  logic [rcfs_pkg::RAW_W-1:0]  button_raw_0;
  logic [rcfs_pkg::RAW_W-1:0]  button_raw_1;
  logic [rcfs_pkg::RAW_W-1:0]  button_raw_2;
  logic [rcfs_pkg::RAW_W-1:0]  button_raw_3;
  logic                        frame_failsafe;
  logic                        frame_lost;
  logic [rcfs_pkg::IDX_W-1:0]  button_index;

  modport source (
    output valid, action, throttle_raw, steer_raw, button_raw_0, button_raw_1,
           button_raw_2, button_raw_3, frame_failsafe, frame_lost, button_index,
    input  ready
  );
  modport sink (
    input  valid, action, throttle_raw, steer_raw, button_raw_0, button_raw_1,
           button_raw_2, button_raw_3, frame_failsafe, frame_lost, button_index,
    output ready
  );
endinterface

// File: rtl/rcfs_out_if.sv
interface rcfs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rcfs_pkg::VAL_W-1:0]    throttle;
  logic signed [rcfs_pkg::VAL_W-1:0]    steer;
  logic                                 in_failsafe;
  logic [rcfs_pkg::MAX_BTNS-1:0]        button_states;
  logic [rcfs_pkg::MAX_BTNS-1:0]        button_edges;
  logic                                 edge_taken;

  modport source (
    output valid, throttle, steer, in_failsafe, button_states, button_edges, edge_taken,
    input  ready
  );
  modport sink (
    input  valid, throttle, steer, in_failsafe, button_states, button_edges, edge_taken,
    output ready
  );
endinterface

// File: rtl/rc_link_failsafe_supervisor.sv
// RC link failsafe supervisor.
// items (sink): one transfer per action: frame, millisecond tick or button edge query.
// results (source): exactly one transfer per accepted item, showing the state after
//   the item: scaled throttle/steer, failsafe flag, button levels, pending edges and
//   the edge taken by a query.
// APB port: five registers at byte addresses 0,4,..,16; write only while idle.
// Sequence: a good frame while active runs two scalings through one restoring
//   divider, one quotient bit per cycle: for each channel a load state, 22 division
//   steps and a finish state, then one commit state. Any other item goes from
//   accept straight to the commit state.
// The block takes one item at a time; items.ready is high only in idle, so the next
//   item is taken only after the commit of the last one.
// The result sits in an output register; the next item is accepted and worked on
//   while it waits, but that item's commit holds until results takes the old one.
// Reset (rst, synchronous): registers to defaults, failsafe set, no frame seen,
//   counters, levels and edges cleared, no result pending.
module rc_link_failsafe_supervisor #(
  parameter int BUTTON_COUNT = rcfs_pkg::DEF_BUTTON_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  rcfs_in_if.sink                      items,
  rcfs_out_if.source                   results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rcfs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rcfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_DIV, S_FIN, S_COMMIT
  } state_t;

  // Configuration registers
  logic             receiver_active;
  logic [RAW_W-1:0] raw_min;
  logic [RAW_W-1:0] raw_max;
  logic [RAW_W-1:0] button_threshold;
  logic [MS_W-1:0]  timeout_ms;

  // Block state
  logic signed [VAL_W-1:0] throttle_value;
  logic signed [VAL_W-1:0] steer_value;
  logic                    failsafe_flag;
  logic                    ever_received;
  logic [MS_W-1:0]         elapsed_ms;
  logic [MAX_BTNS-1:0]     pressed_levels;
  logic [MAX_BTNS-1:0]     pending_edges;

  // Captured item
  logic [ACT_W-1:0] c_action;
  logic [RAW_W-1:0] c_throttle;
  logic [RAW_W-1:0] c_steer;
  logic [RAW_W-1:0] c_btn [MAX_BTNS];
  logic             c_bad;
  logic [IDX_W-1:0] c_index;

  // Sequencer and divider
  state_t              state;
  logic                chan;
  logic [STEP_W-1:0]   step;
  logic [RAW_W-1:0]    rem;
  logic [NUM_W-1:0]    dvd;
  logic [RAW_W-1:0]    den;
  logic                qneg;
  logic                span_zero;
  logic signed [VAL_W-1:0] t_res;
  logic signed [VAL_W-1:0] s_res;

  logic out_valid;
  logic out_free;

  // APB
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_ACTIVE:    prdata = {31'd0, receiver_active};
      REG_RAW_MIN:   prdata = {21'd0, raw_min};
      REG_RAW_MAX:   prdata = {21'd0, raw_max};
      REG_THRESHOLD: prdata = {21'd0, button_threshold};
      REG_TIMEOUT:   prdata = {16'd0, timeout_ms};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_active  <= RST_ACTIVE;
      raw_min          <= RST_RAW_MIN;
      raw_max          <= RST_RAW_MAX;
      button_threshold <= RST_THRESHOLD;
      timeout_ms       <= RST_TIMEOUT;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_ACTIVE:    receiver_active  <= pwdata[0];
        REG_RAW_MIN:   raw_min          <= pwdata[RAW_W-1:0];
        REG_RAW_MAX:   raw_max          <= pwdata[RAW_W-1:0];
        REG_THRESHOLD: button_threshold <= pwdata[RAW_W-1:0];
        REG_TIMEOUT:   timeout_ms       <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Buttons in use
  logic [MAX_BTNS-1:0] used_mask;
  always_comb begin
    for (int i = 0; i < MAX_BTNS; i++) begin
      used_mask[i] = (i < BUTTON_COUNT);
    end
  end

  // Divider operand setup for the selected channel
  logic [RAW_W-1:0]  ld_raw;
  logic [RAW_W:0]    ld_diff;
  logic [RAW_W:0]    ld_span;
  logic [RAW_W-1:0]  ld_dmag;
  logic [RAW_W-1:0]  ld_smag;
  logic [NUM_W-1:0]  ld_ext;
  logic [NUM_W-1:0]  ld_num;

  always_comb begin
    ld_raw  = chan ? c_steer : c_throttle;
    ld_diff = {1'b0, ld_raw} - {1'b0, raw_min};
    ld_span = {1'b0, raw_max} - {1'b0, raw_min};
    ld_dmag = ld_diff[RAW_W] ? RAW_W'(-ld_diff) : ld_diff[RAW_W-1:0];
    ld_smag = ld_span[RAW_W] ? RAW_W'(-ld_span) : ld_span[RAW_W-1:0];
    // x * 2000 = x * 2048 - x * 32 - x * 16
    ld_ext  = {{(NUM_W-RAW_W){1'b0}}, ld_dmag};
    ld_num  = (ld_ext << 11) - (ld_ext << 5) - (ld_ext << 4);
  end

  // One restoring division step
  logic [RAW_W:0]   dv_sh;
  logic [RAW_W:0]   dv_sub;
  logic             dv_ge;
  always_comb begin
    dv_sh  = {rem, dvd[NUM_W-1]};
    dv_ge  = (dv_sh >= {1'b0, den});
    dv_sub = dv_sh - {1'b0, den};
  end

  // Quotient to scaled, saturated value
  logic signed [QEXT_W-1:0] fin_q;
  logic signed [QEXT_W-1:0] fin_v;
  logic signed [VAL_W-1:0]  fin_res;
  always_comb begin
    fin_q = qneg ? -$signed({2'b00, dvd}) : $signed({2'b00, dvd});
    fin_v = fin_q - QEXT_W'(SCALE_OFFSET);
    if (span_zero) begin
      fin_res = '0;
    end else if (fin_v > QEXT_W'(SAT_MAX)) begin
      fin_res = VAL_W'(SAT_MAX);
    end else if (fin_v < QEXT_W'(SAT_MIN)) begin
      fin_res = VAL_W'(SAT_MIN);
    end else begin
      fin_res = fin_v[VAL_W-1:0];
    end
  end

  // State update of the captured item
  logic signed [VAL_W-1:0] tv_next;
  logic signed [VAL_W-1:0] sv_next;
  logic                    fs_next;
  logic                    ever_next;
  logic [MS_W-1:0]         ms_next;
  logic [MAX_BTNS-1:0]     lvl_next;
  logic [MAX_BTNS-1:0]     edg_next;
  logic                    taken_next;
  logic                    hi;

  always_comb begin
    tv_next    = throttle_value;
    sv_next    = steer_value;
    fs_next    = failsafe_flag;
    ever_next  = ever_received;
    ms_next    = elapsed_ms;
    lvl_next   = pressed_levels;
    edg_next   = pending_edges;
    taken_next = 1'b0;
    hi         = 1'b0;
    if (c_action == ACT_FRAME && receiver_active) begin
      if (c_bad) begin
        fs_next  = 1'b1;
        tv_next  = '0;
        sv_next  = '0;
        edg_next = '0;
      end else begin
        ms_next   = '0;
        ever_next = 1'b1;
        fs_next   = 1'b0;
        tv_next   = t_res;
        sv_next   = s_res;
        for (int i = 0; i < MAX_BTNS; i++) begin
          hi = (c_btn[i] > button_threshold);
          if (used_mask[i]) begin
            if (hi && !pressed_levels[i]) edg_next[i] = 1'b1;
            lvl_next[i] = hi;
          end
        end
      end
    end else if (c_action == ACT_TICK && receiver_active) begin
      if (elapsed_ms != {MS_W{1'b1}}) ms_next = elapsed_ms + 1'b1;
    end else if (c_action == ACT_EDGE) begin
      if (!c_index[IDX_W-1] && used_mask[c_index[1:0]]) begin
        taken_next = pending_edges[c_index[1:0]];
        edg_next[c_index[1:0]] = 1'b0;
      end
    end
    // Watchdog after frames and ticks
    if ((c_action == ACT_FRAME || c_action == ACT_TICK) && receiver_active) begin
      if (!ever_next || ms_next > timeout_ms) begin
        fs_next  = 1'b1;
        tv_next  = '0;
        sv_next  = '0;
        edg_next = '0;
      end
    end
  end

  assign items.ready = (state == S_IDLE);
  assign out_free    = !out_valid || results.ready;
  assign results.valid = out_valid;

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      chan           <= 1'b0;
      step           <= '0;
      out_valid      <= 1'b0;
      throttle_value <= '0;
      steer_value    <= '0;
      failsafe_flag  <= 1'b1;
      ever_received  <= 1'b0;
      elapsed_ms     <= '0;
      pressed_levels <= '0;
      pending_edges  <= '0;
    end else begin
      // Result register: loaded on commit, cleared once taken
      if (state == S_COMMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (items.valid) begin
            c_action   <= items.action;
            c_throttle <= items.throttle_raw;
            c_steer    <= items.steer_raw;
            c_btn[0]   <= items.button_raw_0;
            c_btn[1]   <= items.button_raw_1;
            c_btn[2]   <= items.button_raw_2;
            c_btn[3]   <= items.button_raw_3;
            c_bad      <= items.frame_failsafe || items.frame_lost;
            c_index    <= items.button_index;
            chan       <= 1'b0;
            if (items.action == ACT_FRAME && receiver_active &&
                !items.frame_failsafe && !items.frame_lost) begin
              state <= S_LOAD;
            end else begin
              state <= S_COMMIT;
            end
          end
        end
        S_LOAD: begin
          rem       <= '0;
          dvd       <= ld_num;
          den       <= ld_smag;
          qneg      <= ld_diff[RAW_W] ^ ld_span[RAW_W];
          span_zero <= (ld_span == '0);
          step      <= '0;
          state     <= S_DIV;
        end
        S_DIV: begin
          rem  <= dv_ge ? dv_sub[RAW_W-1:0] : dv_sh[RAW_W-1:0];
          dvd  <= {dvd[NUM_W-2:0], dv_ge};
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) state <= S_FIN;
        end
        S_FIN: begin
          if (chan) begin
            s_res <= fin_res;
            state <= S_COMMIT;
          end else begin
            t_res <= fin_res;
            chan  <= 1'b1;
            state <= S_LOAD;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            throttle_value        <= tv_next;
            steer_value           <= sv_next;
            failsafe_flag         <= fs_next;
            ever_received         <= ever_next;
            elapsed_ms            <= ms_next;
            pressed_levels        <= lvl_next;
            pending_edges         <= edg_next;
            results.throttle      <= tv_next;
            results.steer         <= sv_next;
            results.in_failsafe   <= fs_next;
            results.button_states <= lvl_next;
            results.button_edges  <= edg_next;
            results.edge_taken    <= taken_next;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import rcfs_pkg::*;

  localparam int BTN_COUNT = DEF_BUTTON_COUNT;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int HOLD_MAX = 17;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASE_ITEMS = 157;

  typedef struct {
    logic [ACT_W-1:0]               action;
    logic [RAW_W-1:0]               throttle_raw;
    logic [RAW_W-1:0]               steer_raw;
    logic [MAX_BTNS-1:0][RAW_W-1:0] btn_raw;
    logic                           frame_failsafe;
    logic                           frame_lost;
    logic [IDX_W-1:0]               button_index;
    int                             hold_max;
  } rc_item_t;

  typedef struct {
    logic signed [VAL_W-1:0] throttle;
    logic signed [VAL_W-1:0] steer;
    logic                    in_failsafe;
    logic [MAX_BTNS-1:0]     button_states;
    logic [MAX_BTNS-1:0]     button_edges;
    logic                    edge_taken;
  } link_status_t;

  bit          clk;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rcfs_in_if  items_if ();
  rcfs_out_if results_if ();

  rc_link_failsafe_supervisor #(.BUTTON_COUNT(BTN_COUNT)) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copies, reset values
  bit              cfg_active    = RST_ACTIVE;
  bit [RAW_W-1:0]  cfg_raw_min   = RST_RAW_MIN;
  bit [RAW_W-1:0]  cfg_raw_max   = RST_RAW_MAX;
  bit [RAW_W-1:0]  cfg_threshold = RST_THRESHOLD;
  bit [MS_W-1:0]   cfg_timeout   = RST_TIMEOUT;

  // link state copy
  logic signed [VAL_W-1:0] lk_throttle = '0;
  logic signed [VAL_W-1:0] lk_steer    = '0;
  bit                      lk_failsafe = 1'b1;
  bit                      lk_seen     = 1'b0;
  bit [MS_W-1:0]           lk_elapsed  = '0;
  bit [MAX_BTNS-1:0]       lk_levels   = '0;
  bit [MAX_BTNS-1:0]       lk_edges    = '0;

  rc_item_t     tx_q[$];
  link_status_t status_q[$];
  rc_item_t     cur_item;
  link_status_t want_now;

  int queued_total, accepted_total, results_seen;
  int failsafe_seen, edges_taken_seen, setups_applied, mismatches;

  logic src_took, sink_took;
  int   src_wait, sink_wait, sink_gap_max, sink_style_left;
  bit   src_drawn;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // linear map of one raw channel, saturated to 16 bits
  function automatic logic signed [VAL_W-1:0] scale_raw(input logic [RAW_W-1:0] raw);
    int span, q;
    span = int'(cfg_raw_max) - int'(cfg_raw_min);
    if (span == 0) return '0;
    q = ((int'(raw) - int'(cfg_raw_min)) * SCALE_SPAN) / span - SCALE_OFFSET;
    if (q > SAT_MAX) q = SAT_MAX;
    if (q < SAT_MIN) q = SAT_MIN;
    return q[VAL_W-1:0];
  endfunction

  function automatic void enter_failsafe();
    lk_failsafe = 1'b1;
    lk_throttle = '0;
    lk_steer    = '0;
    lk_edges    = '0;
  endfunction

  // apply one item to the link state copy and return the status it shows
  function automatic link_status_t supervise_item(input rc_item_t r);
    link_status_t s;
    bit hi;
    bit taken;
    taken = 1'b0;
    if (r.action == ACT_FRAME && cfg_active) begin
      if (r.frame_failsafe || r.frame_lost) begin
        enter_failsafe();
      end else begin
        lk_elapsed  = '0;
        lk_seen     = 1'b1;
        lk_failsafe = 1'b0;
        lk_throttle = scale_raw(r.throttle_raw);
        lk_steer    = scale_raw(r.steer_raw);
        for (int i = 0; i < MAX_BTNS; i++) begin
          if (i < BTN_COUNT) begin
            hi = r.btn_raw[i] > cfg_threshold;
            if (hi && !lk_levels[i]) lk_edges[i] = 1'b1;
            lk_levels[i] = hi;
          end
        end
      end
    end else if (r.action == ACT_TICK && cfg_active) begin
      if (lk_elapsed != '1) lk_elapsed++;
    end else if (r.action == ACT_EDGE) begin
      if (r.button_index < BTN_COUNT && r.button_index < MAX_BTNS) begin
        taken = lk_edges[r.button_index];
        lk_edges[r.button_index] = 1'b0;
      end
    end
    // watchdog after frames and ticks
    if ((r.action == ACT_FRAME || r.action == ACT_TICK) && cfg_active) begin
      if (!lk_seen || lk_elapsed > cfg_timeout) enter_failsafe();
    end
    s.throttle      = lk_throttle;
    s.steer         = lk_steer;
    s.in_failsafe   = lk_failsafe;
    s.button_states = lk_levels;
    s.button_edges  = lk_edges;
    s.edge_taken    = taken;
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t, result %0d: %s", $time, results_seen, what);
  endtask

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return HOLD_MAX;
    endcase
  endfunction

  // item with every field random
  function automatic rc_item_t noise_item(input int hold);
    rc_item_t r;
    r.action       = ACT_W'($urandom_range(0, 3));
    r.throttle_raw = RAW_W'($urandom_range(0, 2047));
    r.steer_raw    = RAW_W'($urandom_range(0, 2047));
    for (int i = 0; i < MAX_BTNS; i++) r.btn_raw[i] = RAW_W'($urandom_range(0, 2047));
    r.frame_failsafe = 1'($urandom_range(0, 1));
    r.frame_lost     = 1'($urandom_range(0, 1));
    r.button_index   = IDX_W'($urandom_range(0, 7));
    r.hold_max       = hold;
    return r;
  endfunction

  task automatic push_item(input rc_item_t r);
    tx_q.push_back(r);
    queued_total++;
  endtask

  task automatic queue_frame(input int thr, input int str, input int b0, input int b1,
                             input int b2, input int b3, input bit fs, input bit lost);
    rc_item_t r;
    r = noise_item(0);
    r.action = ACT_FRAME;
    r.throttle_raw = RAW_W'(thr);
    r.steer_raw = RAW_W'(str);
    r.btn_raw[0] = RAW_W'(b0);
    r.btn_raw[1] = RAW_W'(b1);
    r.btn_raw[2] = RAW_W'(b2);
    r.btn_raw[3] = RAW_W'(b3);
    r.frame_failsafe = fs;
    r.frame_lost = lost;
    push_item(r);
  endtask

  task automatic queue_tick();
    rc_item_t r;
    r = noise_item(0);
    r.action = ACT_TICK;
    push_item(r);
  endtask

  task automatic queue_edge_query(input int idx);
    rc_item_t r;
    r = noise_item(0);
    r.action = ACT_EDGE;
    r.button_index = IDX_W'(idx);
    push_item(r);
  endtask

  // unused action code: must leave the state alone
  task automatic queue_spare_item();
    rc_item_t r;
    r = noise_item(0);
    r.action = ACT_SPARE;
    push_item(r);
  endtask

  function automatic logic [RAW_W-1:0] channel_draw();
    int lo, hi;
    lo = (cfg_raw_min < cfg_raw_max) ? int'(cfg_raw_min) : int'(cfg_raw_max);
    hi = (cfg_raw_min < cfg_raw_max) ? int'(cfg_raw_max) : int'(cfg_raw_min);
    case ($urandom_range(0, 4))
      0: return RAW_W'($urandom_range(0, 2047));
      1: return cfg_raw_min;
      2: return cfg_raw_max;
      default: return RAW_W'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] button_draw();
    case ($urandom_range(0, 4))
      0: return RAW_W'($urandom_range(0, 2047));
      1: return (cfg_threshold == 2047) ? 11'd2047 :
                RAW_W'($urandom_range(cfg_threshold + 1, 2047));
      2: return RAW_W'($urandom_range(0, cfg_threshold));
      3: return cfg_threshold;
      default: return (cfg_threshold == 2047) ? 11'd2047 : cfg_threshold + 11'd1;
    endcase
  endfunction

  // mostly well-formed frames, tick runs and edge queries; some bad frames and noise
  task automatic queue_random_traffic(input int n);
    rc_item_t r;
    int made, next_switch, gap, kind, run;
    made = 0;
    next_switch = 0;
    gap = 0;
    while (made < n) begin
      if (made >= next_switch) begin
        gap = pick_gap_max();
        next_switch = made + 50;
      end
      kind = $urandom_range(0, 99);
      r = noise_item(gap);
      if (kind < 40) begin
        r.action = ACT_FRAME;
        r.frame_failsafe = 1'b0;
        r.frame_lost = 1'b0;
        r.throttle_raw = channel_draw();
        r.steer_raw = channel_draw();
        for (int i = 0; i < MAX_BTNS; i++) r.btn_raw[i] = button_draw();
        push_item(r);
        made++;
      end else if (kind < 48) begin
        r.action = ACT_FRAME;
        {r.frame_failsafe, r.frame_lost} = 2'($urandom_range(1, 3));
        push_item(r);
        made++;
      end else if (kind < 78) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
        for (int k = 0; k < run; k++) begin
          r = noise_item(gap);
          r.action = ACT_TICK;
          push_item(r);
          made++;
        end
      end else if (kind < 95) begin
        r.action = ACT_EDGE;
        r.button_index = IDX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(4, 7)
                                                             : $urandom_range(0, 3));
        push_item(r);
        made++;
      end else begin
        r.action = ACT_SPARE;
        push_item(r);
      end
    end
  endtask

  // APB write, then read back the same register
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ACTIVE:    cfg_active    = value[0];
      REG_RAW_MIN:   cfg_raw_min   = value[RAW_W-1:0];
      REG_RAW_MAX:   cfg_raw_max   = value[RAW_W-1:0];
      REG_THRESHOLD: cfg_threshold = value[RAW_W-1:0];
      REG_TIMEOUT:   cfg_timeout   = value[MS_W-1:0];
      default: ;
    endcase
    case (idx)
      REG_ACTIVE:    want = 32'(cfg_active);
      REG_RAW_MIN:   want = 32'(cfg_raw_min);
      REG_RAW_MAX:   want = 32'(cfg_raw_max);
      REG_THRESHOLD: want = 32'(cfg_threshold);
      default:       want = 32'(cfg_timeout);
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("register %0d read %0h, want %0h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setup(input bit act, input int rmin, input int rmax, input int thr,
                             input int tmo);
    write_reg(REG_ACTIVE, 32'(act));
    write_reg(REG_RAW_MIN, rmin);
    write_reg(REG_RAW_MAX, rmax);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_TIMEOUT, tmo);
    setups_applied++;
  endtask

  // wait until every queued item is taken and every result is in
  task automatic settle();
    while (accepted_total != queued_total || status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender: present items at the falling edge, with a drawn gap before each
  always @(negedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
      src_drawn = 1'b0;
    end else if (!items_if.valid || src_took) begin
      if (!src_drawn && tx_q.size() != 0) begin
        src_wait = $urandom_range(0, tx_q[0].hold_max);
        src_drawn = 1'b1;
      end
      if (src_drawn && src_wait == 0) begin
        cur_item = tx_q.pop_front();
        items_if.action         <= cur_item.action;
        items_if.throttle_raw   <= cur_item.throttle_raw;
        items_if.steer_raw      <= cur_item.steer_raw;
        items_if.button_raw_0   <= cur_item.btn_raw[0];
        items_if.button_raw_1   <= cur_item.btn_raw[1];
        items_if.button_raw_2   <= cur_item.btn_raw[2];
        items_if.button_raw_3   <= cur_item.btn_raw[3];
        items_if.frame_failsafe <= cur_item.frame_failsafe;
        items_if.frame_lost     <= cur_item.frame_lost;
        items_if.button_index   <= cur_item.button_index;
        items_if.valid          <= 1'b1;
        src_drawn = 1'b0;
      end else begin
        items_if.valid <= 1'b0;
        if (src_drawn) src_wait--;
      end
    end
  end

  // input transfer: predict the status it will produce
  always @(posedge clk) begin
    if (rst) begin
      src_took <= 1'b0;
    end else begin
      src_took <= items_if.valid && items_if.ready;
      if (items_if.valid && items_if.ready) begin
        status_q.push_back(supervise_item(cur_item));
        accepted_total++;
      end
    end
  end

  // receiver: stall a drawn number of cycles after each transfer, style changes in stretches
  always @(negedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      sink_wait = 0;
      sink_style_left = 0;
    end else begin
      if (sink_took) begin
        if (sink_style_left == 0) begin
          sink_gap_max = pick_gap_max();
          sink_style_left = 40;
        end
        sink_style_left--;
        sink_wait = $urandom_range(0, sink_gap_max);
      end
      if (sink_took || !results_if.ready) begin
        if (sink_wait > 0) begin
          results_if.ready <= 1'b0;
          sink_wait--;
        end else begin
          results_if.ready <= 1'b1;
        end
      end
    end
  end

  // result transfer: compare with the oldest expected status
  always @(posedge clk) begin
    if (rst) begin
      sink_took <= 1'b0;
    end else begin
      sink_took <= results_if.valid && results_if.ready;
      if (results_if.valid && results_if.ready) begin
        results_seen++;
        if (status_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want_now = status_q.pop_front();
          if (results_if.throttle !== want_now.throttle)
            report_mismatch($sformatf("throttle %0d, want %0d",
                                      results_if.throttle, want_now.throttle));
          if (results_if.steer !== want_now.steer)
            report_mismatch($sformatf("steer %0d, want %0d", results_if.steer, want_now.steer));
          if (results_if.in_failsafe !== want_now.in_failsafe)
            report_mismatch($sformatf("in_failsafe %b, want %b",
                                      results_if.in_failsafe, want_now.in_failsafe));
          if (results_if.button_states !== want_now.button_states)
            report_mismatch($sformatf("button_states %b, want %b",
                                      results_if.button_states, want_now.button_states));
          if (results_if.button_edges !== want_now.button_edges)
            report_mismatch($sformatf("button_edges %b, want %b",
                                      results_if.button_edges, want_now.button_edges));
          if (results_if.edge_taken !== want_now.edge_taken)
            report_mismatch($sformatf("edge_taken %b, want %b",
                                      results_if.edge_taken, want_now.edge_taken));
          if (want_now.in_failsafe) failsafe_seen++;
          if (want_now.edge_taken) edges_taken_seen++;
        end
      end
    end
  end

  initial begin
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    items_if.valid          = 1'b0;
    items_if.action         = ACT_FRAME;
    items_if.throttle_raw   = '0;
    items_if.steer_raw      = '0;
    items_if.button_raw_0   = '0;
    items_if.button_raw_1   = '0;
    items_if.button_raw_2   = '0;
    items_if.button_raw_3   = '0;
    items_if.frame_failsafe = 1'b0;
    items_if.frame_lost     = 1'b0;
    items_if.button_index   = '0;
    results_if.ready        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: default registers
    queue_tick();                                      // no frame yet: stays in failsafe
    queue_spare_item();
    queue_edge_query(0);                               // nothing latched
    queue_frame(172, 1811, 2047, 1401, 1400, 0, 0, 0); // ends of the span, threshold edge
    queue_frame(0, 2047, 2047, 2047, 2047, 2047, 0, 0); // beyond the span, all pressed
    queue_edge_query(0);
    queue_edge_query(0);
    queue_edge_query(3);
    queue_edge_query(4);                               // out of range indexes
    queue_edge_query(7);
    queue_frame(1000, 1000, 0, 0, 0, 0, 1, 0);         // receiver failsafe: edges dropped
    queue_frame(991, 991, 0, 0, 0, 0, 0, 0);
    queue_frame(1000, 1000, 2047, 2047, 2047, 2047, 0, 1); // lost frame
    queue_frame(991, 700, 2047, 2047, 2047, 2047, 0, 0);
    queue_tick();
    settle();

    // directed: short timeout trips after two ticks
    write_reg(REG_TIMEOUT, 1);
    queue_frame(500, 1500, 2047, 0, 2047, 0, 0, 0);
    queue_tick();
    queue_tick();
    queue_edge_query(2);
    settle();

    // directed: receiver inactive holds everything but edge queries
    write_reg(REG_ACTIVE, 0);
    queue_frame(1200, 300, 0, 0, 0, 0, 0, 0);
    queue_tick();
    queue_edge_query(1);
    settle();

    // random phases; the first ones pin register extremes
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: apply_setup(1'b1, 1024, 1024, 0, 0);
        1: apply_setup(1'b1, 0, 1, 2047, 16'hFFFF);
        2: apply_setup(1'b1, 1, 0, 1400, 3);
        3: apply_setup(1'b1, 2047, 0, $urandom_range(0, 2047), 7);
        4: apply_setup(1'b0, int'(RST_RAW_MIN), int'(RST_RAW_MAX), int'(RST_THRESHOLD),
                       int'(RST_TIMEOUT));
        default: begin
          case ($urandom_range(0, 3))
            0: apply_setup(1'b1, $urandom_range(100, 250), $urandom_range(1700, 1900),
                           $urandom_range(0, 2047), $urandom_range(0, 20));
            1: apply_setup(1'b1, $urandom_range(0, 2047), $urandom_range(0, 2047),
                           $urandom_range(0, 2047), $urandom_range(0, 65535));
            2: apply_setup(1'b1, $urandom_range(1024, 2047), $urandom_range(0, 1023),
                           $urandom_range(0, 2047), $urandom_range(0, 12));
            default: apply_setup(1'b1, 900, 900, $urandom_range(0, 2047),
                                 $urandom_range(1, 8));
          endcase
        end
      endcase
      queue_random_traffic((ph == 4) ? 40 : PHASE_ITEMS);
      settle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d checked results over %0d register setups",
             accepted_total, results_seen, setups_applied + 2);
    $display("results in failsafe: %0d, latched edges taken: %0d, mismatches: %0d",
             failsafe_seen, edges_taken_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
